### sv/dogx_pkg.sv
// ----------------------------------------------------------------------------
// dogx_pkg
// shared types, widths, register indexes and reset values of the dog
// scale-space extremum detector
// ----------------------------------------------------------------------------
package dogx_pkg;

  localparam int SAMPLE_W      = 17;
  localparam int COL_W         = 10;
  localparam int ROW_W         = 16;
  localparam int WIDTH_W       = 11;
  localparam int THR_W         = 16;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int LAYERS        = 3;
  localparam int LINES         = 2;
  localparam int WIN           = 3;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int SIZE_FLOOR    = 3;
  localparam int LINE_ENTRY_W  = LAYERS * LINES * SAMPLE_W;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONTRAST_THR = 2'd2;

  localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [ROW_W-1:0]   IMAGE_HEIGHT_RST = 16'd480;
  localparam logic [THR_W-1:0]   CONTRAST_THR_RST = 16'd256;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef sample_t [LAYERS-1:0] triple_t;
  // [layer][row][col]
  typedef sample_t [LAYERS-1:0][WIN-1:0][WIN-1:0] window_t;

endpackage

### sv/dogx_ram.sv
// ----------------------------------------------------------------------------
// dogx_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module dogx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/dogx_judge.sv
// ----------------------------------------------------------------------------
// dogx_judge
// contrast test and 26-neighbour max/min test on a 3x3x3 window
// ----------------------------------------------------------------------------
module dogx_judge (
  input  dogx_pkg::window_t               win,
  input  logic [dogx_pkg::THR_W-1:0]      threshold,
  output logic                            extremum
);

  logic signed [dogx_pkg::SAMPLE_W-1:0] ctr;
  logic [dogx_pkg::SAMPLE_W-1:0]        mag;
  logic                                 is_max;
  logic                                 is_min;

  assign ctr = $signed(win[1][1][1]);

  always_comb begin
    is_max = 1'b1;
    is_min = 1'b1;
    for (int l = 0; l < dogx_pkg::LAYERS; l++) begin
      for (int r = 0; r < dogx_pkg::WIN; r++) begin
        for (int k = 0; k < dogx_pkg::WIN; k++) begin
          if (!(l == 1 && r == 1 && k == 1)) begin
            if (ctr < $signed(win[l][r][k])) begin
              is_max = 1'b0;
            end
            if (ctr > $signed(win[l][r][k])) begin
              is_min = 1'b0;
            end
          end
        end
      end
    end
  end

  // magnitude of -65536 still fits 17 bits unsigned
  assign mag = ctr[dogx_pkg::SAMPLE_W-1] ? dogx_pkg::SAMPLE_W'(-ctr)
                                         : dogx_pkg::SAMPLE_W'(ctr);

  assign extremum = (mag > {1'b0, threshold}) && (is_max || is_min);

endmodule

### sv/dog_scale_space_extremum_detect_core.sv
// ----------------------------------------------------------------------------
// dog_scale_space_extremum_detect_core
// pipeline: an accepted item passes the stage 1 register, then the output register
// throughput: one item per cycle unless the output stalls, set by one read and one
// write of the line ram per item; a same-column follow-up item takes the write
// data by forwarding. reset: synchronous, active low; after reset a clearing pass
// zeroes all MAX_WIDTH line ram entries, with in_stall high; config writes are taken always
// ----------------------------------------------------------------------------
module dog_scale_space_extremum_detect_core #(
  parameter int MAX_WIDTH = dogx_pkg::MAX_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [dogx_pkg::SAMPLE_W-1:0] in_sample_below,
  input  logic signed [dogx_pkg::SAMPLE_W-1:0] in_sample_center,
  input  logic signed [dogx_pkg::SAMPLE_W-1:0] in_sample_above,
  input  logic                                 in_frame_start,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [dogx_pkg::COL_W-1:0]           out_center_col,
  output logic [dogx_pkg::ROW_W-1:0]           out_center_row,
  output logic                                 out_judged,
  output logic                                 out_extremum,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dogx_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dogx_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int EW     = (ADDR_W + 1 > dogx_pkg::WIDTH_W) ? ADDR_W + 1 : dogx_pkg::WIDTH_W;
  localparam int ROW_W  = dogx_pkg::ROW_W;
  localparam int SW     = dogx_pkg::SAMPLE_W;

  // config registers
  logic [dogx_pkg::WIDTH_W-1:0] image_width_r;
  logic [ROW_W-1:0]             image_height_r;
  logic [dogx_pkg::THR_W-1:0]   contrast_thr_r;

  // position
  logic [ADDR_W-1:0] col_r, col_nxt, col0;
  logic [ROW_W-1:0]  row_r, row_nxt, row0, row_inc;
  logic [EW-1:0]     w_ext, w_eff, col_inc;
  logic [ROW_W-1:0]  h_eff;

  // clearing pass
  logic              clearing_r;
  logic [ADDR_W-1:0] clr_cnt_r;

  // stage 1
  logic                          v1_r;
  logic [ADDR_W-1:0]             s1_col_r;
  dogx_pkg::triple_t             s1_smp_r;
  logic [dogx_pkg::COL_W-1:0]    s1_ccol_r;
  logic [ROW_W-1:0]              s1_crow_r;
  logic                          s1_judged_r;
  logic                          fwd_v_r;
  logic [dogx_pkg::LINE_ENTRY_W-1:0] fwd_data_r;

  // window and line ram
  dogx_pkg::window_t                 win_r, win_nxt;
  logic [dogx_pkg::LINE_ENTRY_W-1:0] ram_q, line_rd, line_wr, ram_wdata;
  logic                              ram_we;
  logic [ADDR_W-1:0]                 ram_waddr;

  logic accept, adv, ext;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= dogx_pkg::IMAGE_WIDTH_RST;
      image_height_r <= dogx_pkg::IMAGE_HEIGHT_RST;
      contrast_thr_r <= dogx_pkg::CONTRAST_THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dogx_pkg::REG_IMAGE_WIDTH:  image_width_r  <= cfg_data[dogx_pkg::WIDTH_W-1:0];
        dogx_pkg::REG_IMAGE_HEIGHT: image_height_r <= cfg_data;
        dogx_pkg::REG_CONTRAST_THR: contrast_thr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake
  assign adv      = v1_r && (!out_valid || !out_stall);
  assign in_stall = clearing_r || (v1_r && !adv);
  assign accept   = in_valid && !in_stall;

  // effective sizes
  always_comb begin
    w_ext = EW'(image_width_r);
    if (w_ext > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else if (w_ext < EW'(dogx_pkg::SIZE_FLOOR)) begin
      w_eff = EW'(dogx_pkg::SIZE_FLOOR);
    end else begin
      w_eff = w_ext;
    end
    h_eff = (image_height_r < ROW_W'(dogx_pkg::SIZE_FLOOR)) ? ROW_W'(dogx_pkg::SIZE_FLOOR)
                                                           : image_height_r;
  end

  // position of the incoming pixel and of the one after it
  always_comb begin
    if (in_frame_start) begin
      col0 = '0;
      row0 = '0;
    end else if (EW'(col_r) >= w_eff) begin
      col0 = '0;
      row0 = row_r + 1'b1;
    end else begin
      col0 = col_r;
      row0 = row_r;
    end
    if (row0 >= h_eff) begin
      row0 = '0;
    end
    col_inc = EW'(col0) + 1'b1;
    row_inc = row0 + 1'b1;
    if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (row_inc >= h_eff) ? '0 : row_inc;
    end else begin
      col_nxt = ADDR_W'(col_inc);
      row_nxt = row0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // clearing pass over the line ram
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == ADDR_W'(MAX_WIDTH - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // stage 1 register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      if (accept) begin
        v1_r    <= 1'b1;
        fwd_v_r <= adv && (col0 == s1_col_r);
      end else if (adv) begin
        v1_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col_r    <= col0;
      s1_smp_r    <= {in_sample_above, in_sample_center, in_sample_below};
      s1_ccol_r   <= (col0 != '0 && row0 != '0) ? dogx_pkg::COL_W'(col0 - 1'b1) : '0;
      s1_crow_r   <= (col0 != '0 && row0 != '0) ? (row0 - 1'b1) : '0;
      s1_judged_r <= (col0 >= ADDR_W'(2)) && (row0 >= ROW_W'(2));
    end
    if (adv) begin
      fwd_data_r <= line_wr;
    end
  end

  // line ram
  assign ram_we    = clearing_r || adv;
  assign ram_waddr = clearing_r ? clr_cnt_r : s1_col_r;
  assign ram_wdata = clearing_r ? '0 : line_wr;

  dogx_ram #(
    .WIDTH (dogx_pkg::LINE_ENTRY_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (col0),
    .rdata (ram_q)
  );

  assign line_rd = fwd_v_r ? fwd_data_r : ram_q;

  // window shift and line update
  always_comb begin
    line_wr = line_rd;
    win_nxt = win_r;
    for (int l = 0; l < dogx_pkg::LAYERS; l++) begin
      for (int r = 0; r < dogx_pkg::WIN; r++) begin
        win_nxt[l][r][0] = win_r[l][r][1];
        win_nxt[l][r][1] = win_r[l][r][2];
      end
      win_nxt[l][0][2] = line_rd[(l * dogx_pkg::LINES) * SW +: SW];
      win_nxt[l][1][2] = line_rd[(l * dogx_pkg::LINES + 1) * SW +: SW];
      win_nxt[l][2][2] = s1_smp_r[l];
      line_wr[(l * dogx_pkg::LINES) * SW +: SW]     = line_rd[(l * dogx_pkg::LINES + 1) * SW +: SW];
      line_wr[(l * dogx_pkg::LINES + 1) * SW +: SW] = s1_smp_r[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (adv) begin
      win_r <= win_nxt;
    end
  end

  dogx_judge u_judge (
    .win       (win_nxt),
    .threshold (contrast_thr_r),
    .extremum  (ext)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_center_col <= s1_ccol_r;
      out_center_row <= s1_crow_r;
      out_judged     <= s1_judged_r;
      out_extremum   <= s1_judged_r && ext;
    end
  end

endmodule

### sv/dogx_checker.sv
// ----------------------------------------------------------------------------
// dogx_checker
// port-level checks of the extremum detector, bound to the top level
// ----------------------------------------------------------------------------
module dogx_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [dogx_pkg::COL_W-1:0]     out_center_col,
  input logic [dogx_pkg::ROW_W-1:0]     out_center_row,
  input logic                           out_judged,
  input logic                           out_extremum
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_center_col) &&
      $stable(out_center_row) && $stable(out_judged) && $stable(out_extremum))
    else $error("stalled result changed");

  // an extremum is always a judged center
  a_ext_judged: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_extremum |-> out_judged)
    else $error("extremum on unjudged center");

  // a judged center lies off the top and left border
  a_judged_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_judged |-> out_center_col != '0 && out_center_row != '0)
    else $error("judged center on border");

endmodule

bind dog_scale_space_extremum_detect_core dogx_checker u_dogx_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_center_col  (out_center_col),
  .out_center_row  (out_center_row),
  .out_judged      (out_judged),
  .out_extremum    (out_extremum)
);

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the dog scale-space extremum detector: streams
// pixel triples with random gaps and output stalls, predicts each verdict
// with its own line buffer and 3x3x3 window model, checks results in order
// ----------------------------------------------------------------------------
module tb;
  import dogx_pkg::*;

  localparam int SAMPLE_PEAK    = 65535;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int REPORT_LINES   = 40;
  localparam int SMALL_ITEMS    = 1050;

  typedef enum int {FILL_NOISE, FILL_STEPS, FILL_PEAKS, FILL_EXTREMES} fill_style_t;

  typedef struct packed {
    sample_t below;
    sample_t center;
    sample_t above;
    logic    frame_start;
  } pixel_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             judged;
    logic             extremum;
  } verdict_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  sample_t                in_sample_below = '0;
  sample_t                in_sample_center = '0;
  sample_t                in_sample_above = '0;
  logic                   in_frame_start = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [COL_W-1:0]       out_center_col;
  logic [ROW_W-1:0]       out_center_row;
  logic                   out_judged;
  logic                   out_extremum;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  dog_scale_space_extremum_detect_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_below (in_sample_below),
    .in_sample_center(in_sample_center),
    .in_sample_above (in_sample_above),
    .in_frame_start  (in_frame_start),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_center_col  (out_center_col),
    .out_center_row  (out_center_row),
    .out_judged      (out_judged),
    .out_extremum    (out_extremum),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // detector state mirror
  logic [WIDTH_W-1:0] width_setting = IMAGE_WIDTH_RST;
  logic [ROW_W-1:0]   height_setting = IMAGE_HEIGHT_RST;
  logic [THR_W-1:0]   threshold_setting = CONTRAST_THR_RST;
  sample_t            line_mem [LAYERS][LINES][MAX_WIDTH_DEF];
  sample_t            win_regs [LAYERS][WIN][WIN];
  int unsigned        col_pos = 0;
  int unsigned        row_pos = 0;

  pixel_t   pixel_queue [$];
  verdict_t verdict_queue [$];
  int       mismatches = 0;
  int       hold_requests = 0;
  int       hold_served = 0;
  logic     sender_quiet = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned active_width();
    if (width_setting < SIZE_FLOOR) return SIZE_FLOOR;
    if (width_setting > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return width_setting;
  endfunction

  function automatic int unsigned active_height();
    return (height_setting < SIZE_FLOOR) ? SIZE_FLOOR : height_setting;
  endfunction

  function automatic int unsigned gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
  endfunction

  function automatic verdict_t judge_pixel(pixel_t px);
    sample_t     fresh [LAYERS];
    sample_t     mid;
    int unsigned w, h, col, row, mag;
    logic        peak, pit;
    verdict_t    v;
    w = active_width();
    h = active_height();
    if (px.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end else if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    col = col_pos;
    row = row_pos;
    fresh[0] = px.below;
    fresh[1] = px.center;
    fresh[2] = px.above;
    for (int l = 0; l < LAYERS; l++) begin
      for (int r = 0; r < WIN; r++) begin
        win_regs[l][r][0] = win_regs[l][r][1];
        win_regs[l][r][1] = win_regs[l][r][2];
      end
      win_regs[l][0][2] = line_mem[l][0][col];
      win_regs[l][1][2] = line_mem[l][1][col];
      win_regs[l][2][2] = fresh[l];
      line_mem[l][0][col] = line_mem[l][1][col];
      line_mem[l][1][col] = fresh[l];
    end
    v = '0;
    if (col >= 1 && row >= 1) begin
      v.col = COL_W'(col - 1);
      v.row = ROW_W'(row - 1);
    end
    if (col >= 2 && row >= 2) begin
      v.judged = 1'b1;
      mid = win_regs[1][1][1];
      mag = (mid < 0) ? -int'(mid) : int'(mid);
      if (mag > threshold_setting) begin
        peak = 1'b1;
        pit = 1'b1;
        for (int l = 0; l < LAYERS; l++)
          for (int r = 0; r < WIN; r++)
            for (int k = 0; k < WIN; k++) begin
              if (l == 1 && r == 1 && k == 1) continue;
              if (mid < win_regs[l][r][k]) peak = 1'b0;
              if (mid > win_regs[l][r][k]) pit = 1'b0;
            end
        v.extremum = peak | pit;
      end
    end
    col_pos = col + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = row + 1;
      if (row_pos >= h) row_pos = 0;
    end
    return v;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (mismatches < REPORT_LINES)
      $display("tb: mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // ---------------- driver ----------------
  logic        in_calm = 1'b0;
  logic        in_took;
  int unsigned in_gap_left = 0;
  pixel_t      next_px;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap_left <= 0;
    end else begin
      in_took = in_valid && !in_stall;
      if (in_took) begin
        next_px = '{in_sample_below, in_sample_center, in_sample_above, in_frame_start};
        verdict_queue = {verdict_queue, judge_pixel(next_px)};
      end
      if ($urandom_range(0, 99) == 0) in_calm <= ~in_calm;
      if (in_valid && in_stall) begin
      end else if (in_gap_left > 0) begin
        in_valid <= 1'b0;
        in_gap_left <= in_gap_left - 1;
      end else if (in_took && !in_calm && !sender_quiet && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        in_gap_left <= gap_len() - 1;
      end else if (pixel_queue.size() > 0) begin
        next_px = pixel_queue.pop_front();
        in_valid <= 1'b1;
        in_sample_below <= next_px.below;
        in_sample_center <= next_px.center;
        in_sample_above <= next_px.above;
        in_frame_start <= next_px.frame_start;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------- monitor ----------------
  logic        out_calm = 1'b0;
  int unsigned out_stall_left = 0;
  verdict_t    want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (verdict_queue.size() == 0) begin
          report_mismatch("unexpected result, col", out_center_col, 0);
        end else begin
          want = verdict_queue.pop_front();
          if (out_center_col !== want.col)
            report_mismatch("center_col", out_center_col, want.col);
          if (out_center_row !== want.row)
            report_mismatch("center_row", out_center_row, want.row);
          if (out_judged !== want.judged)
            report_mismatch("judged", out_judged, want.judged);
          if (out_extremum !== want.extremum)
            report_mismatch("extremum flag", out_extremum, want.extremum);
        end
      end
      if ($urandom_range(0, 99) == 0) out_calm <= ~out_calm;
      if (out_stall_left > 0) begin
        out_stall <= 1'b1;
        out_stall_left <= out_stall_left - 1;
      end else if (hold_served < hold_requests) begin
        out_stall <= 1'b1;
        out_stall_left <= LONG_HOLD - 1;
        hold_served <= hold_served + 1;
      end else if (!out_calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        out_stall_left <= gap_len() - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------- watchdog ----------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------- stimulus ----------------
  function automatic sample_t pick_sample(fill_style_t fill);
    int v;
    case (fill)
      FILL_NOISE: v = int'($urandom_range(0, 2 * SAMPLE_PEAK)) - SAMPLE_PEAK;
      FILL_STEPS: v = (int'($urandom_range(0, 6)) - 3) * 64;
      FILL_PEAKS: begin
        v = ($urandom_range(0, 11) == 0) ? int'($urandom_range(257, SAMPLE_PEAK))
                                          : (int'($urandom_range(0, 2)) - 1) * 300;
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: begin
        case ($urandom_range(0, 4))
          0: v = 0;
          1: v = 1;
          2: v = -1;
          3: v = SAMPLE_PEAK;
          default: v = -SAMPLE_PEAK;
        endcase
      end
    endcase
    return sample_t'(v);
  endfunction

  task automatic push_pixel(logic fs, int b, int c, int a);
    pixel_queue = {pixel_queue, pixel_t'{sample_t'(b), sample_t'(c), sample_t'(a), fs}};
  endtask

  // frames in raster order, mostly marked, some with stray frame starts
  task automatic queue_items(int unsigned count, logic noise_ok);
    pixel_t      px;
    fill_style_t fill;
    int unsigned frame_len, pos;
    logic        marked, noisy;
    pos = 0;
    frame_len = active_width() * active_height();
    fill = FILL_NOISE;
    marked = 1'b0;
    noisy = 1'b0;
    for (int unsigned i = 0; i < count; i++) begin
      if (pos == 0) begin
        fill = fill_style_t'($urandom_range(0, 3));
        marked = ($urandom_range(0, 3) != 0);
        noisy = noise_ok && ($urandom_range(0, 7) == 0);
      end
      px.frame_start = (pos == 0 && marked) || (noisy && $urandom_range(0, 31) == 0);
      px.below = pick_sample(fill);
      px.center = pick_sample(fill);
      px.above = pick_sample(fill);
      pixel_queue = {pixel_queue, px};
      pos = px.frame_start ? 1 : pos + 1;
      if (pos >= frame_len) pos = 0;
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:  width_setting = val[WIDTH_W-1:0];
      REG_IMAGE_HEIGHT: height_setting = val;
      REG_CONTRAST_THR: threshold_setting = val;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pixel_queue.size() != 0 || verdict_queue.size() != 0 || in_valid)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_items(int unsigned count, logic noise_ok);
    @(negedge clk);
    queue_items(count, noise_ok);
    wait_drained();
  endtask

  int unsigned small_items;
  int unsigned n;

  initial begin
    for (int l = 0; l < LAYERS; l++) begin
      for (int r = 0; r < WIN; r++)
        for (int k = 0; k < WIN; k++) win_regs[l][r][k] = '0;
      for (int r = 0; r < LINES; r++)
        for (int k = 0; k < MAX_WIDTH_DEF; k++) line_mem[l][r][k] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset sizes with extreme samples
    @(negedge clk);
    push_pixel(1'b1, SAMPLE_PEAK, -SAMPLE_PEAK, 0);
    push_pixel(1'b0, -SAMPLE_PEAK, SAMPLE_PEAK, 1);
    push_pixel(1'b0, 0, 0, -1);
    push_pixel(1'b0, SAMPLE_PEAK, SAMPLE_PEAK, -SAMPLE_PEAK);
    wait_drained();

    // undersized width and height act as 3, junk above the width field
    write_reg(REG_IMAGE_WIDTH, 16'hF802);
    write_reg(REG_IMAGE_HEIGHT, 16'd0);
    write_reg(REG_CONTRAST_THR, 16'd0);
    @(negedge clk);
    // peak frame, then a trough frame reached by wrap at frame end
    for (int i = 0; i < 9; i++)
      push_pixel(i == 0, 100, (i == 4) ? SAMPLE_PEAK : 100, 100);
    for (int i = 0; i < 9; i++)
      push_pixel(1'b0, 200, (i == 4) ? -SAMPLE_PEAK : 200, 200);
    wait_drained();
    small_items = 22;

    write_reg(REG_IMAGE_WIDTH, 16'd5);
    write_reg(REG_IMAGE_HEIGHT, 16'd4);
    write_reg(REG_CONTRAST_THR, 16'd256);
    run_items(120, 1'b1);

    // receiver holds off while the sender keeps offering
    write_reg(REG_IMAGE_WIDTH, 16'd3);
    write_reg(REG_IMAGE_HEIGHT, 16'd3);
    write_reg(REG_CONTRAST_THR, 16'd0);
    sender_quiet = 1'b1;
    @(negedge clk);
    queue_items(150, 1'b1);
    hold_requests = hold_requests + 1;
    wait_drained();
    sender_quiet = 1'b0;

    write_reg(REG_IMAGE_WIDTH, 16'd7);
    write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
    write_reg(REG_CONTRAST_THR, 16'hFFFF);
    run_items(100, 1'b1);
    small_items += 370;

    // full-width rows, then an oversized width that clamps to the same
    write_reg(REG_IMAGE_WIDTH, 16'd1024);
    write_reg(REG_IMAGE_HEIGHT, 16'd1);
    write_reg(REG_CONTRAST_THR, 16'd100);
    run_items(100, 1'b0);
    write_reg(REG_IMAGE_WIDTH, 16'h07FF);
    run_items(200, 1'b0);
    small_items += 300;

    while (small_items < SMALL_ITEMS) begin
      if ($urandom_range(0, 2) != 0) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) :
            ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(3, 12);
        write_reg(REG_IMAGE_WIDTH, {5'($urandom_range(0, 31)), 11'(n)});
      end
      if ($urandom_range(0, 2) != 0) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
        write_reg(REG_IMAGE_HEIGHT, 16'(n));
      end
      if ($urandom_range(0, 2) != 0) begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 600);
        write_reg(REG_CONTRAST_THR, 16'(n));
      end
      n = $urandom_range(30, 140);
      run_items(n, 1'b1);
      small_items += n;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
